// ===== sv/prvs_pkg.sv =====
// ----------------------------------------------------------------------------
// prvs_pkg
// Shared types and constants of the page replacement victim selector.
// ----------------------------------------------------------------------------
package prvs_pkg;

  localparam int PAGE_W  = 16;
  localparam int STAMP_W = 32;
  localparam int FIDX_W  = 4;

  // opcodes of an input item
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ACCESS = 2'd1;
  localparam logic [1:0] OP_EVICT  = 2'd2;
  localparam logic [1:0] OP_CHOOSE = 2'd3;

  // replacement policies
  localparam logic [2:0] POL_FIFO   = 3'd0;
  localparam logic [2:0] POL_CLOCK  = 3'd1;
  localparam logic [2:0] POL_MRU    = 3'd2;
  localparam logic [2:0] POL_RANDOM = 3'd3;
  localparam logic [2:0] POL_OPT    = 3'd4;

  // configuration register indexes
  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_SEED   = 1'b1;

  // random generator
  localparam logic [31:0] LCG_MUL = 32'd1103515245;
  localparam logic [31:0] LCG_INC = 32'd12345;
  localparam int          RAND_HI = 30;  // (seed / 65536) % 32768 -> bits 30..16
  localparam int          RAND_W  = 15;

  localparam logic [STAMP_W-1:0] NEVER_USED = '1;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_ACCESS,
    CMD_EVICT,
    CMD_CHOOSE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [FIDX_W-1:0]   frame_index;
    logic [PAGE_W-1:0]   page;
    logic [STAMP_W-1:0]  stamp;
    logic [STAMP_W-1:0]  next_ref;
  } cmd_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [FIDX_W-1:0] frame;
    logic              found;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QRD,
    ST_MSCAN,
    ST_CLK,
    ST_CFALL,
    ST_RCNT,
    ST_LCG,
    ST_DIV,
    ST_RSEL,
    ST_PAGE,
    ST_DONE
  } back_state_t;

endpackage

// ===== sv/prvs_front.sv =====
// ----------------------------------------------------------------------------
// prvs_front
// Accepts input items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module prvs_front
  import prvs_pkg::*;
#(
  parameter int FRAME_COUNT = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic [FIDX_W-1:0]  in_frame_index,
  input  logic [PAGE_W-1:0]  in_page_number,
  input  logic [STAMP_W-1:0] in_time_stamp,
  input  logic [STAMP_W-1:0] in_next_use_position,
  output logic               cmd_valid,
  output cmd_t               cmd,
  input  logic               cmd_pop
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       cls;
  logic       keep;
  logic       push;

  // classify: out-of-range frames are dropped (not for choose), load of page zero is an evict
  always_comb begin
    cls.frame_index = in_frame_index;
    cls.page        = in_page_number;
    cls.stamp       = in_time_stamp;
    cls.next_ref    = in_next_use_position;
    keep            = 1'b1;
    case (in_opcode)
      OP_CHOOSE: cls.kind = CMD_CHOOSE;
      OP_LOAD:   cls.kind = (in_page_number != '0) ? CMD_LOAD : CMD_EVICT;
      OP_ACCESS: cls.kind = CMD_ACCESS;
      default:   cls.kind = CMD_EVICT;
    endcase
    if (in_opcode != OP_CHOOSE && 32'(in_frame_index) >= 32'(FRAME_COUNT)) begin
      keep = 1'b0;
    end
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall && keep;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== sv/prvs_back.sv =====
// ----------------------------------------------------------------------------
// prvs_back
// Frame table, FIFO page queue and the sequencer that applies events and
// picks a victim under the configured policy.
// ----------------------------------------------------------------------------
module prvs_back
  import prvs_pkg::*;
#(
  parameter int FRAME_COUNT = 16,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [2:0]  policy,
  input  logic        seed_ld,
  input  logic [31:0] seed_val,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  output logic        res_valid,
  output res_t        res,
  input  logic        res_take
);

  localparam int FIW = $clog2(FRAME_COUNT);
  localparam int IW  = $clog2(FRAME_COUNT + 1);
  localparam int QIW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  back_state_t state_r, state_nxt;

  logic [FRAME_COUNT-1:0] occ_r, ref_r;
  logic [PAGE_W-1:0]      mem_page [FRAME_COUNT];
  logic [STAMP_W-1:0]     mem_last [FRAME_COUNT];
  logic [STAMP_W-1:0]     mem_next [FRAME_COUNT];
  logic [PAGE_W-1:0]      rd_page_r;
  logic [STAMP_W-1:0]     rd_last_r, rd_next_r;

  logic [PAGE_W-1:0]      q_mem [QUEUE_DEPTH];
  logic [QIW-1:0]         q_head_r, q_tail_r;
  logic [QCW-1:0]         q_cnt_r;
  logic [PAGE_W-1:0]      cand_r;

  logic [FIW-1:0]         hand_r;
  logic [31:0]            seed_r;
  logic [IW-1:0]          idx_r, n_r, cnt_r, k_r;
  logic [IW-1:0]          rem_r;
  logic [3:0]             step_r;
  logic                   pv_r;
  logic [FIW-1:0]         pidx_r;
  logic                   have_r;
  logic [STAMP_W-1:0]     best_val_r;
  logic [FIW-1:0]         best_r;
  logic [FIW-1:0]         victim_r;
  logic                   found_r;

  logic [FIW-1:0]         fidx, cmd_f, hand_inc;
  logic                   issue, scan_done, occ_p, mscan_hit, clk_sweep, clk_hit;
  logic                   ev_load, ev_access, ev_evict, q_push;
  logic [FIW-1:0]         rd_addr;
  logic [IW:0]            rem_sh;
  logic [31:0]            seed_fix;

  assign fidx      = idx_r[FIW-1:0];
  assign cmd_f     = FIW'(cmd.frame_index);
  assign hand_inc  = (hand_r == FIW'(FRAME_COUNT - 1)) ? '0 : hand_r + 1'b1;
  assign issue     = (state_r == ST_MSCAN) && (idx_r != IW'(FRAME_COUNT));
  assign scan_done = (idx_r == IW'(FRAME_COUNT)) && !pv_r;
  assign occ_p     = occ_r[pidx_r];
  assign mscan_hit = pv_r && occ_p &&
                     (((policy == POL_FIFO) && (rd_page_r == cand_r)) ||
                      ((policy == POL_OPT) && (rd_next_r == NEVER_USED)));
  assign clk_sweep = (n_r != IW'(FRAME_COUNT));
  assign clk_hit   = clk_sweep && occ_r[hand_r] && !ref_r[hand_r];
  assign rem_sh    = {rem_r, seed_r[5'(RAND_HI) - {1'b0, step_r}]};
  assign seed_fix  = (seed_r == '0) ? 32'd1 : seed_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid && cmd.kind == CMD_CHOOSE) begin
          case (policy)
            POL_FIFO:   state_nxt = (q_cnt_r == '0) ? ST_DONE : ST_QRD;
            POL_CLOCK:  state_nxt = ST_CLK;
            POL_MRU:    state_nxt = ST_MSCAN;
            POL_OPT:    state_nxt = ST_MSCAN;
            POL_RANDOM: state_nxt = ST_RCNT;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_QRD: state_nxt = ST_MSCAN;
      ST_MSCAN: begin
        if (mscan_hit) begin
          state_nxt = ST_PAGE;
        end else if (scan_done) begin
          if (policy == POL_FIFO) begin
            state_nxt = (q_cnt_r != '0) ? ST_QRD : ST_DONE;
          end else begin
            state_nxt = have_r ? ST_PAGE : ST_DONE;
          end
        end
      end
      ST_CLK: begin
        if (clk_hit) begin
          state_nxt = ST_PAGE;
        end else if (!clk_sweep) begin
          state_nxt = ST_CFALL;
        end
      end
      ST_CFALL: begin
        if (idx_r == IW'(FRAME_COUNT)) begin
          state_nxt = ST_DONE;
        end else if (occ_r[fidx]) begin
          state_nxt = ST_PAGE;
        end
      end
      ST_RCNT: begin
        if (idx_r == IW'(FRAME_COUNT)) begin
          state_nxt = (cnt_r == '0) ? ST_DONE : ST_LCG;
        end
      end
      ST_LCG: state_nxt = ST_DIV;
      ST_DIV: begin
        if (step_r == 4'(RAND_W - 1)) begin
          state_nxt = ST_RSEL;
        end
      end
      ST_RSEL: begin
        if (idx_r == IW'(FRAME_COUNT)) begin
          state_nxt = ST_DONE;
        end else if (occ_r[fidx] && k_r == rem_r) begin
          state_nxt = ST_PAGE;
        end
      end
      ST_PAGE: state_nxt = ST_DONE;
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and strobes
  always_comb begin
    cmd_pop   = (state_r == ST_IDLE) && cmd_valid;
    ev_load   = cmd_pop && (cmd.kind == CMD_LOAD);
    ev_access = cmd_pop && (cmd.kind == CMD_ACCESS) && occ_r[cmd_f];
    ev_evict  = cmd_pop && (cmd.kind == CMD_EVICT);
    q_push    = ev_load && (policy == POL_FIFO) && (q_cnt_r != QCW'(QUEUE_DEPTH));
    rd_addr   = issue ? fidx : victim_r;
    res_valid = (state_r == ST_DONE);
    res.found = found_r;
    res.frame = found_r ? FIDX_W'(victim_r) : '0;
    res.page  = found_r ? rd_page_r : '0;
  end

  // frame table and queue storage
  always_ff @(posedge clk) begin
    if (ev_load) begin
      mem_page[cmd_f] <= cmd.page;
    end
    if (ev_load || ev_access) begin
      mem_last[cmd_f] <= cmd.stamp;
      mem_next[cmd_f] <= cmd.next_ref;
    end
    rd_page_r <= mem_page[rd_addr];
    rd_last_r <= mem_last[rd_addr];
    rd_next_r <= mem_next[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem[q_tail_r] <= cmd.page;
    end
    if (state_r == ST_QRD) begin
      cand_r <= q_mem[q_head_r];
    end
  end

  // control state and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      occ_r      <= '0;
      ref_r      <= '0;
      q_head_r   <= '0;
      q_tail_r   <= '0;
      q_cnt_r    <= '0;
      hand_r     <= '0;
      seed_r     <= 32'd1;
      idx_r      <= '0;
      n_r        <= '0;
      cnt_r      <= '0;
      k_r        <= '0;
      rem_r      <= '0;
      step_r     <= '0;
      pv_r       <= 1'b0;
      pidx_r     <= '0;
      have_r     <= 1'b0;
      best_val_r <= '0;
      best_r     <= '0;
      victim_r   <= '0;
      found_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pv_r    <= issue;
      pidx_r  <= fidx;
      if (seed_ld) begin
        seed_r <= seed_val;
      end
      case (state_r)
        ST_IDLE: begin
          idx_r   <= '0;
          n_r     <= '0;
          cnt_r   <= '0;
          have_r  <= 1'b0;
          found_r <= 1'b0;
          if (ev_load) begin
            occ_r[cmd_f] <= 1'b1;
            ref_r[cmd_f] <= 1'b0;
          end
          if (ev_access) begin
            ref_r[cmd_f] <= 1'b1;
          end
          if (ev_evict) begin
            occ_r[cmd_f] <= 1'b0;
            ref_r[cmd_f] <= 1'b0;
          end
          if (q_push) begin
            q_tail_r <= (q_tail_r == QIW'(QUEUE_DEPTH - 1)) ? '0 : q_tail_r + 1'b1;
            q_cnt_r  <= q_cnt_r + 1'b1;
          end
        end
        ST_QRD: begin
          // pop the head; the candidate is checked against the table
          q_head_r <= (q_head_r == QIW'(QUEUE_DEPTH - 1)) ? '0 : q_head_r + 1'b1;
          q_cnt_r  <= q_cnt_r - 1'b1;
          idx_r    <= '0;
        end
        ST_MSCAN: begin
          if (issue) begin
            idx_r <= idx_r + 1'b1;
          end
          if (mscan_hit) begin
            victim_r <= pidx_r;
            found_r  <= 1'b1;
          end else if (scan_done) begin
            victim_r <= best_r;
            found_r  <= have_r && (policy != POL_FIFO);
          end else if (pv_r && occ_p) begin
            if (policy == POL_MRU && (!have_r || rd_last_r >= best_val_r)) begin
              have_r     <= 1'b1;
              best_r     <= pidx_r;
              best_val_r <= rd_last_r;
            end
            if (policy == POL_OPT && (!have_r || rd_next_r > best_val_r)) begin
              have_r     <= 1'b1;
              best_r     <= pidx_r;
              best_val_r <= rd_next_r;
            end
          end
        end
        ST_CLK: begin
          if (clk_sweep) begin
            hand_r <= hand_inc;
            n_r    <= n_r + 1'b1;
            if (clk_hit) begin
              victim_r <= hand_r;
              found_r  <= 1'b1;
            end else if (occ_r[hand_r]) begin
              ref_r[hand_r] <= 1'b0;
            end
          end
        end
        ST_CFALL: begin
          if (idx_r != IW'(FRAME_COUNT)) begin
            idx_r <= idx_r + 1'b1;
            if (occ_r[fidx]) begin
              victim_r <= fidx;
              found_r  <= 1'b1;
              hand_r   <= (fidx == FIW'(FRAME_COUNT - 1)) ? '0 : fidx + 1'b1;
            end
          end
        end
        ST_RCNT: begin
          if (idx_r != IW'(FRAME_COUNT)) begin
            idx_r <= idx_r + 1'b1;
            cnt_r <= cnt_r + IW'(occ_r[fidx]);
          end
        end
        ST_LCG: begin
          seed_r <= 32'(seed_fix * LCG_MUL + LCG_INC);
          rem_r  <= '0;
          step_r <= '0;
        end
        ST_DIV: begin
          // restoring remainder, one dividend bit per cycle
          step_r <= step_r + 1'b1;
          rem_r  <= (rem_sh >= {1'b0, cnt_r}) ? IW'(rem_sh - {1'b0, cnt_r}) : IW'(rem_sh);
          idx_r  <= '0;
          k_r    <= '0;
        end
        ST_RSEL: begin
          if (idx_r != IW'(FRAME_COUNT)) begin
            idx_r <= idx_r + 1'b1;
            if (occ_r[fidx]) begin
              k_r <= k_r + 1'b1;
              if (k_r == rem_r) begin
                victim_r <= fidx;
                found_r  <= 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sv/page_replacement_victim_selector_top.sv =====
// ----------------------------------------------------------------------------
// page_replacement_victim_selector_top
// Frame table with a victim selector for FIFO, clock, MRU, random and
// optimal replacement.
// ----------------------------------------------------------------------------
// Load, access and evict items pass through the command queue to the table
// and sustain one item per cycle while the back sequencer is idle. A
// choose-victim item works one frame per cycle through the table in the
// back sequencer: FIFO, MRU and optimal scan the table (FIFO repeats the
// scan for each stale queue entry it pops), clock sweeps the hand over every
// frame and then falls back to the lowest occupied frame, and random counts
// occupancy, takes an LCG step, forms the remainder bit by bit and walks to
// the selected frame. A two-entry command queue lets the input keep accepting
// while the back is busy, and the output register holds a finished result
// while the back takes the next item. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module page_replacement_victim_selector_top
  import prvs_pkg::*;
#(
  parameter int FRAME_COUNT = 16,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic [FIDX_W-1:0]  in_frame_index,
  input  logic [PAGE_W-1:0]  in_page_number,
  input  logic [STAMP_W-1:0] in_time_stamp,
  input  logic [STAMP_W-1:0] in_next_use_position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [PAGE_W-1:0]  out_victim_page,
  output logic [FIDX_W-1:0]  out_victim_frame,
  output logic               out_victim_found
);

  logic [2:0] policy_r;
  logic       seed_ld;
  logic       cmd_valid, cmd_pop;
  cmd_t       cmd;
  logic       res_valid, res_take;
  res_t       res;
  logic       out_valid_r;
  res_t       out_r;

  // configuration: policy is held here, the seed is loaded into the back
  assign seed_ld = cfg_wr_en && (cfg_index == CFG_SEED);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_FIFO;
    end else if (cfg_wr_en && cfg_index == CFG_POLICY) begin
      policy_r <= cfg_wdata[2:0];
    end
  end

  prvs_front #(
    .FRAME_COUNT(FRAME_COUNT)
  ) u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_opcode            (in_opcode),
    .in_frame_index       (in_frame_index),
    .in_page_number       (in_page_number),
    .in_time_stamp        (in_time_stamp),
    .in_next_use_position (in_next_use_position),
    .cmd_valid            (cmd_valid),
    .cmd                  (cmd),
    .cmd_pop              (cmd_pop)
  );

  prvs_back #(
    .FRAME_COUNT(FRAME_COUNT),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .policy    (policy_r),
    .seed_ld   (seed_ld),
    .seed_val  (cfg_wdata),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // output register: take a new result whenever the slot is empty or drains
  assign res_take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_victim_page  = out_r.page;
  assign out_victim_frame = out_r.frame;
  assign out_victim_found = out_r.found;

  // a missing victim reports page and frame zero
  a_none_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_victim_found |-> out_victim_page == '0 && out_victim_frame == '0)
    else $error("no-victim result carries a page or frame");

  // an occupied frame never holds page zero
  a_found_page : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_victim_found |-> out_victim_page != '0)
    else $error("victim found with page zero");

  // reset empties the output register
  a_reset_out : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

// ===== bench/tb_page_replacement_victim_selector_top.sv =====
// ----------------------------------------------------------------------------
// tb_page_replacement_victim_selector_top
// Self-checking bench for the page replacement victim selector.
// ----------------------------------------------------------------------------
// Drive load, access, evict and choose-victim items under every policy and
// several seeds. A frame table kept in the bench predicts each victim. The
// checker compares every result field by field with the oldest prediction.
// Random idling on both channels moves gaps across every phase of a scan.
// ----------------------------------------------------------------------------
module tb_page_replacement_victim_selector_top;
  import prvs_pkg::*;

  localparam int NFRAMES   = 16;
  localparam int QDEPTH    = 16;
  localparam int SETTLE    = 100;   // settling wait after the last victim is in
  localparam int STUCK_MAX = 5000;  // cycles without any handshake

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic               cfg_index = CFG_POLICY;
  logic [31:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_opcode = OP_LOAD;
  logic [FIDX_W-1:0]  in_frame_index = '0;
  logic [PAGE_W-1:0]  in_page_number = '0;
  logic [STAMP_W-1:0] in_time_stamp = '0;
  logic [STAMP_W-1:0] in_next_use_position = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [PAGE_W-1:0]  out_victim_page;
  logic [FIDX_W-1:0]  out_victim_frame;
  logic               out_victim_found;

  page_replacement_victim_selector_top dut (.*);

  always #5 clk = ~clk;

  // frame table mirror
  logic [2:0]         policy;
  logic               occ [NFRAMES];
  logic [PAGE_W-1:0]  fpage [NFRAMES];
  logic               refd [NFRAMES];
  logic [STAMP_W-1:0] last_use [NFRAMES];
  logic [STAMP_W-1:0] next_ref [NFRAMES];
  logic [PAGE_W-1:0]  load_order [QDEPTH];
  int                 q_head, q_count, hand;
  logic [31:0]        lcg_seed;

  res_t victim_q[$];
  int   errors = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   stuck = 0;

  // Hold the receiver stall at the set rate.
  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  function automatic int frame_holding(logic [PAGE_W-1:0] pg);
    if (pg == 0) return -1;
    for (int i = 0; i < NFRAMES; i++)
      if (occ[i] && fpage[i] == pg) return i;
    return -1;
  endfunction

  function automatic int pick_victim_frame();
    int best, cnt, r, k;
    logic [STAMP_W-1:0] bv;
    best = -1;
    case (policy)
      POL_FIFO: begin
        // pop stale page ids until one still sits in a frame
        while (q_count > 0) begin
          best = frame_holding(load_order[q_head]);
          q_head = (q_head + 1) % QDEPTH;
          q_count--;
          if (best >= 0) return best;
        end
        return -1;
      end
      POL_CLOCK: begin
        if (hand >= NFRAMES) hand = 0;
        for (int n = 0; n < NFRAMES; n++) begin
          k = hand;
          hand = (k + 1) % NFRAMES;
          if (occ[k]) begin
            if (!refd[k]) return k;
            refd[k] = 1'b0;
          end
        end
        for (int i = 0; i < NFRAMES; i++)
          if (occ[i]) begin
            hand = (i + 1) % NFRAMES;
            return i;
          end
        return -1;
      end
      POL_MRU: begin
        bv = '0;
        for (int i = 0; i < NFRAMES; i++)
          if (occ[i] && (best < 0 || last_use[i] >= bv)) begin
            best = i;
            bv = last_use[i];
          end
        return best;
      end
      POL_RANDOM: begin
        cnt = 0;
        for (int i = 0; i < NFRAMES; i++) if (occ[i]) cnt++;
        if (cnt == 0) return -1;
        if (lcg_seed == 0) lcg_seed = 32'd1;
        lcg_seed = lcg_seed * LCG_MUL + LCG_INC;
        r = int'(lcg_seed[30:16]) % cnt;
        k = 0;
        for (int i = 0; i < NFRAMES; i++)
          if (occ[i]) begin
            if (k == r) return i;
            k++;
          end
        return -1;
      end
      POL_OPT: begin
        bv = '0;
        for (int i = 0; i < NFRAMES; i++)
          if (occ[i]) begin
            if (next_ref[i] == NEVER_USED) return i;
            if (best < 0 || next_ref[i] > bv) begin
              best = i;
              bv = next_ref[i];
            end
          end
        return best;
      end
      default: return -1;
    endcase
  endfunction

  // Advance the mirror by one accepted item; queue a victim for choose.
  function automatic void apply_item(logic [1:0] op, int f, logic [PAGE_W-1:0] pg,
                                     logic [STAMP_W-1:0] ts, logic [STAMP_W-1:0] nu);
    int   v;
    res_t r;
    if (op == OP_CHOOSE) begin
      v = pick_victim_frame();
      r = '0;
      if (v >= 0) begin
        r.page  = fpage[v];
        r.frame = v[FIDX_W-1:0];
        r.found = 1'b1;
      end
      victim_q.push_back(r);
    end else if (op == OP_LOAD && pg != 0) begin
      occ[f] = 1'b1;
      fpage[f] = pg;
      refd[f] = 1'b0;
      last_use[f] = ts;
      next_ref[f] = nu;
      if (policy == POL_FIFO && q_count < QDEPTH) begin
        load_order[(q_head + q_count) % QDEPTH] = pg;
        q_count++;
      end
    end else if (op == OP_ACCESS) begin
      if (occ[f]) begin
        refd[f] = 1'b1;
        last_use[f] = ts;
        next_ref[f] = nu;
      end
    end else begin
      // evict, or load of page zero
      occ[f] = 1'b0;
      refd[f] = 1'b0;
    end
  endfunction

  // Send one item; hold it until the block takes it.
  task automatic send_item(logic [1:0] op, logic [FIDX_W-1:0] f, logic [PAGE_W-1:0] pg,
                           logic [STAMP_W-1:0] ts, logic [STAMP_W-1:0] nu);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_frame_index <= f;
    in_page_number <= pg;
    in_time_stamp <= ts;
    in_next_use_position <= nu;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_item(op, int'(f), pg, ts, nu);
  endtask

  // Drop valid, then wait until every victim is in and the back has settled.
  task automatic drain();
    in_valid <= 1'b0;
    while (victim_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_POLICY) policy = val[2:0];
    else lcg_seed = val;
  endtask

  // Random item: mostly loads and choices over a small page pool so that
  // pages repeat across frames and go stale in the queue.
  task automatic send_random_item();
    logic [1:0]         op;
    logic [PAGE_W-1:0]  pg;
    logic [STAMP_W-1:0] ts, nu;
    int                 sel;
    sel = $urandom_range(99);
    op = (sel < 35) ? OP_LOAD : (sel < 57) ? OP_ACCESS : (sel < 72) ? OP_EVICT : OP_CHOOSE;
    case ($urandom_range(9))
      0:       pg = '0;
      1, 2:    pg = 16'($urandom);
      default: pg = 16'($urandom_range(1, 12));
    endcase
    ts = ($urandom_range(3) == 0) ? $urandom_range(3) : $urandom;
    case ($urandom_range(5))
      0:       nu = NEVER_USED;
      1:       nu = $urandom_range(4);
      default: nu = $urandom;
    endcase
    send_item(op, 4'($urandom_range(NFRAMES - 1)), pg, ts, nu);
  endtask

  task automatic test_directed();
    // empty table: no victim under any policy
    for (int p = POL_FIFO; p <= POL_OPT; p++) begin
      write_reg(CFG_POLICY, 32'(p));
      send_item(OP_CHOOSE, 4'd0, '0, '0, '0);
    end
    write_reg(CFG_POLICY, 32'(POL_FIFO));
    send_item(OP_LOAD, 4'd0, 16'hFFFF, '0, 32'd7);
    send_item(OP_LOAD, 4'd15, 16'd1, '1, '1);
    send_item(OP_LOAD, 4'd7, 16'hFFFF, '1, 32'd7);     // same page twice
    send_item(OP_LOAD, 4'd3, 16'd0, '1, '1);           // load of page zero
    send_item(OP_ACCESS, 4'd5, 16'd9, 32'd3, 32'd3);   // empty frame
    send_item(OP_ACCESS, 4'd15, 16'd0, '1, 32'd7);
    send_item(OP_EVICT, 4'd0, '0, '0, '0);
    send_item(OP_CHOOSE, 4'd0, '0, '0, '0);            // lowest frame of page
    send_item(OP_EVICT, 4'd15, '0, '0, '0);
    send_item(OP_CHOOSE, 4'd0, '0, '0, '0);            // stale head entry
    send_item(OP_CHOOSE, 4'd0, '0, '0, '0);            // queue now empty
    for (int i = 0; i < QDEPTH + 2; i++)               // overfill the queue
      send_item(OP_LOAD, i[3:0], 16'(i + 20), 32'd5, 32'd5);
    write_reg(CFG_POLICY, 32'(POL_CLOCK));
    for (int i = 0; i < NFRAMES; i++) send_item(OP_ACCESS, i[3:0], '0, 32'd5, 32'd5);
    send_item(OP_CHOOSE, 4'd0, '0, '0, '0);            // sweep finds nothing
    write_reg(CFG_POLICY, 32'(POL_MRU));
    send_item(OP_CHOOSE, 4'd0, '0, '0, '0);            // tie: later frame wins
    write_reg(CFG_POLICY, 32'(POL_OPT));
    send_item(OP_CHOOSE, 4'd0, '0, '0, '0);            // tie: earlier frame wins
    write_reg(CFG_POLICY, 32'd7);                      // unknown policy
    send_item(OP_CHOOSE, 4'd0, '0, '0, '0);
    write_reg(CFG_SEED, 32'd0);
    write_reg(CFG_POLICY, 32'(POL_RANDOM));
    send_item(OP_CHOOSE, 4'd0, '0, '0, '0);            // zero seed
  endtask

  task automatic test_policy(logic [2:0] p, logic [31:0] seed, int n);
    write_reg(CFG_SEED, seed);
    write_reg(CFG_POLICY, 32'(p));
    repeat (n) send_random_item();
  endtask

  task automatic test_random_traffic(int idle_in, int idle_out);
    send_idle_pct = idle_in;
    stall_pct = idle_out;
    test_policy(POL_FIFO,   $urandom, 125);
    test_policy(POL_CLOCK,  $urandom, 125);
    test_policy(POL_MRU,    32'hFFFF_FFFF, 125);
    test_policy(POL_RANDOM, $urandom, 60);
    test_policy(POL_RANDOM, 32'hFFFF_FFFF, 65);
    test_policy(POL_OPT,    32'd0, 125);
  endtask

  // Check each result against the oldest victim waiting.
  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (victim_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result page=%h frame=%0d found=%b",
                                   out_victim_page, out_victim_frame, out_victim_found);
      end else begin
        e = victim_q.pop_front();
        if (out_victim_page !== e.page || out_victim_frame !== e.frame ||
            out_victim_found !== e.found) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: expected page=%h frame=%0d found=%b,",
                      " got page=%h frame=%0d found=%b"},
                     e.page, e.frame, e.found,
                     out_victim_page, out_victim_frame, out_victim_found);
        end
      end
    end
  end

  // Watchdog: end the run if no handshake happens for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck >= STUCK_MAX) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    policy = POL_FIFO;
    lcg_seed = 32'd1;
    q_head = 0;
    q_count = 0;
    hand = 0;
    for (int i = 0; i < NFRAMES; i++) begin
      occ[i] = 1'b0;
      fpage[i] = '0;
      refd[i] = 1'b0;
      last_use[i] = '0;
      next_ref[i] = NEVER_USED;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_traffic(37, 56);
    test_random_traffic(56, 37);
    test_random_traffic(0, 0);
    drain();
    if (errors == 0 && victim_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/prvs_pkg.sv
sv/prvs_front.sv
sv/prvs_back.sv
sv/page_replacement_victim_selector_top.sv
bench/tb_page_replacement_victim_selector_top.sv
